// ----- rtl/b3dh_pkg.sv -----
// Shared types, constants and tables for the BLAKE3 double hash block.
`default_nettype none
package b3dh_pkg;

  localparam int MSG_BYTES_DEF = 326;
  localparam int NUM_WORDS     = 96;
  localparam int IDX_W         = 7;
  localparam int LAST_BLOCK    = 5;
  localparam int NUM_ROUNDS    = 7;

  localparam logic [31:0] FLAG_START = 32'h1;
  localparam logic [31:0] FLAG_END   = 32'h2;
  localparam logic [31:0] FLAG_ROOT  = 32'h8;

  localparam logic [31:0] IV [8] = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
  };

  localparam logic [3:0] PERM [16] = '{
    4'd2, 4'd6, 4'd3, 4'd10, 4'd7, 4'd0, 4'd4, 4'd13,
    4'd1, 4'd11, 4'd12, 4'd5, 4'd9, 4'd14, 4'd15, 4'd8
  };

  typedef struct packed {
    logic       init_cv;
    logic       ld_we;
    logic [6:0] ld_word;
    logic       init_v;
    logic       step;
    logic [2:0] phase;
    logic       permute;
    logic       finish;
    logic       load_second;
    logic       second;
    logic [2:0] blk;
    logic [2:0] out_idx;
  } cmd_t;

endpackage
`default_nettype wire

// ----- rtl/b3dh_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module b3dh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 96
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- rtl/b3dh_ctrl.sv -----
// Sequencer for message load, compression rounds and digest output.
`default_nettype none
module b3dh_ctrl import b3dh_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       go,
  output logic            busy,
  output logic            done,
  output logic [6:0]      raddr,
  output cmd_t            cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOAD  = 3'd1;
  localparam logic [2:0] S_INIT  = 3'd2;
  localparam logic [2:0] S_ROUND = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;
  localparam logic [2:0] S_SEC   = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0] state, state_next;
  logic [4:0] cnt, cnt_next;
  logic [2:0] blk, blk_next;
  logic [2:0] rnd, rnd_next;
  logic [2:0] phase, phase_next;
  logic       second, second_next;
  logic [3:0] ld_idx;

  assign ld_idx = cnt[3:0] - 4'd1;
  assign raddr  = {blk, cnt[3:0]};
  assign busy   = (state != S_IDLE);
  assign done   = (state == S_OUT);

  always_comb begin
    state_next  = state;
    cnt_next    = cnt;
    blk_next    = blk;
    rnd_next    = rnd;
    phase_next  = phase;
    second_next = second;
    cmd             = '0;
    cmd.ld_word     = {blk, ld_idx};
    cmd.phase       = phase;
    cmd.second      = second;
    cmd.blk         = blk;
    cmd.out_idx     = cnt[2:0];
    unique case (state)
      S_IDLE: begin
        if (go) begin
          cmd.init_cv = 1'b1;
          blk_next    = '0;
          cnt_next    = '0;
          second_next = 1'b0;
          state_next  = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd.ld_we = (cnt != 5'd0);
        cnt_next  = cnt + 5'd1;
        if (cnt == 5'd16) begin
          state_next = S_INIT;
        end
      end
      S_INIT: begin
        cmd.init_v = 1'b1;
        rnd_next   = '0;
        phase_next = '0;
        state_next = S_ROUND;
      end
      S_ROUND: begin
        cmd.step   = 1'b1;
        phase_next = phase + 3'd1;
        if (phase == 3'd7) begin
          cmd.permute = 1'b1;
          rnd_next    = rnd + 3'd1;
          if (rnd == 3'(NUM_ROUNDS - 1)) begin
            state_next = S_FIN;
          end
        end
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        cnt_next   = '0;
        if (second) begin
          state_next = S_OUT;
        end else if (blk == 3'(LAST_BLOCK)) begin
          second_next = 1'b1;
          state_next  = S_SEC;
        end else begin
          blk_next   = blk + 3'd1;
          state_next = S_LOAD;
        end
      end
      S_SEC: begin
        cmd.load_second = 1'b1;
        state_next      = S_INIT;
      end
      S_OUT: begin
        cnt_next = cnt + 5'd1;
        if (cnt[2:0] == 3'd7) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      cnt    <= '0;
      blk    <= '0;
      rnd    <= '0;
      phase  <= '0;
      second <= 1'b0;
    end else begin
      state  <= state_next;
      cnt    <= cnt_next;
      blk    <= blk_next;
      rnd    <= rnd_next;
      phase  <= phase_next;
      second <= second_next;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/b3dh_dp.sv -----
// Compression datapath: message block, work vector and chain value.
`default_nettype none
module b3dh_dp import b3dh_pkg::*; #(
  parameter int MSG_BYTES = MSG_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire cmd_t        cmd,
  input  wire logic [31:0] rdata,
  output logic      [31:0] digest_word
);

  logic [31:0] m  [16];
  logic [31:0] v  [16];
  logic [31:0] cv [8];
  logic [31:0] m_next [16];
  logic [31:0] v_next [16];
  logic [31:0] masked;
  logic [31:0] blen;
  logic [31:0] flags;

  assign digest_word = cv[cmd.out_idx];

  always_comb begin
    for (int b = 0; b < 4; b++) begin
      masked[8*b +: 8] = ({2'b00, cmd.ld_word, 2'(b)} < 11'(MSG_BYTES)) ?
                         rdata[8*b +: 8] : 8'h00;
    end
  end

  always_comb begin
    flags = '0;
    blen  = 32'd64;
    if (cmd.second) begin
      flags = FLAG_START | FLAG_END | FLAG_ROOT;
      blen  = 32'd32;
    end else begin
      if (cmd.blk == 3'd0) begin
        flags = flags | FLAG_START;
      end
      if (cmd.blk == 3'(LAST_BLOCK)) begin
        flags = flags | FLAG_END | FLAG_ROOT;
        blen  = 32'(MSG_BYTES - 320);
      end
    end
  end

  always_comb begin
    logic [3:0]  ia, ib, ic, id;
    logic [1:0]  j2;
    logic [31:0] xy;
    logic [31:0] s;
    v_next = v;
    for (int j = 0; j < 4; j++) begin
      j2 = 2'(j);
      ia = {2'b00, j2};
      if (!cmd.phase[2]) begin
        ib = {2'b01, j2};
        ic = {2'b10, j2};
        id = {2'b11, j2};
      end else begin
        ib = {2'b01, j2 + 2'd1};
        ic = {2'b10, j2 + 2'd2};
        id = {2'b11, j2 + 2'd3};
      end
      xy = m[{cmd.phase[2], j2, cmd.phase[1]}];
      case (cmd.phase[1:0])
        2'd0: begin
          s = v[ia] + v[ib] + xy;
          v_next[ia] = s;
          v_next[id] = {(v[id] ^ s)} >> 16 | {(v[id] ^ s)} << 16;
        end
        2'd1: begin
          s = v[ic] + v[id];
          v_next[ic] = s;
          v_next[ib] = (v[ib] ^ s) >> 12 | (v[ib] ^ s) << 20;
        end
        2'd2: begin
          s = v[ia] + v[ib] + xy;
          v_next[ia] = s;
          v_next[id] = (v[id] ^ s) >> 8 | (v[id] ^ s) << 24;
        end
        default: begin
          s = v[ic] + v[id];
          v_next[ic] = s;
          v_next[ib] = (v[ib] ^ s) >> 7 | (v[ib] ^ s) << 25;
        end
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      m_next[i] = m[PERM[i]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 8; i++) begin
        cv[i] <= IV[i];
      end
      for (int i = 0; i < 16; i++) begin
        v[i] <= '0;
      end
    end else begin
      if (cmd.init_cv) begin
        for (int i = 0; i < 8; i++) begin
          cv[i] <= IV[i];
        end
      end
      if (cmd.init_v) begin
        for (int i = 0; i < 8; i++) begin
          v[i] <= cv[i];
        end
        for (int i = 0; i < 4; i++) begin
          v[8+i] <= IV[i];
        end
        v[12] <= '0;
        v[13] <= '0;
        v[14] <= blen;
        v[15] <= flags;
      end
      if (cmd.step) begin
        v <= v_next;
      end
      if (cmd.finish) begin
        for (int i = 0; i < 8; i++) begin
          cv[i] <= v[i] ^ v[8+i];
        end
      end
      if (cmd.load_second) begin
        for (int i = 0; i < 8; i++) begin
          cv[i] <= IV[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_we) begin
      m[cmd.ld_word[3:0]] <= masked;
    end
    if (cmd.permute) begin
      m <= m_next;
    end
    if (cmd.load_second) begin
      for (int i = 0; i < 8; i++) begin
        m[i]   <= cv[i];
        m[8+i] <= '0;
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/blake3_double_hash_326b_top.sv -----
// Top level of the BLAKE3 double hash block: store, sequencer and datapath.
//
// Input channel: a beat is taken at a clock edge with start high and busy
// low. Each beat writes msg_word at word_index into the 96-word message
// store; indices 96..127 are dropped. A beat at index 95 also starts the
// hash of the stored buffer and raises busy.
// Each of the six message blocks is read from the store, sets up the work
// vector, runs seven rounds (four parallel mixes, one quarter step per
// cycle) and folds the chain value. The second hash then compresses the
// first digest as a single block.
// Output channel: done is high for one beat per digest word, in order of
// digest_index 0..7 with no gap; is_last marks the eighth. The receiver
// cannot stall. busy falls after the last beat; one hash runs at a time,
// so no input beat is taken while busy is high.
// Reset clears the sequencer and work vector and sets the chain value to
// the IV; the store keeps its content.
`default_nettype none
module blake3_double_hash_326b_top import b3dh_pkg::*; #(
  parameter int MSG_BYTES = MSG_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [31:0] msg_word,
  input  wire logic [6:0]  word_index,
  output logic             done,
  output logic [31:0]      digest_word,
  output logic [2:0]       digest_index,
  output logic             is_last
);

  cmd_t        cmd;
  logic [6:0]  raddr;
  logic [31:0] rdata;
  logic        accept;
  logic        we;
  logic        go;

  assign accept       = start && !busy;
  assign we           = accept && (word_index < 7'(NUM_WORDS));
  assign go           = accept && (word_index == 7'(NUM_WORDS - 1));
  assign digest_index = cmd.out_idx;
  assign is_last      = (cmd.out_idx == 3'd7);

  b3dh_ram #(
    .WIDTH (32),
    .DEPTH (NUM_WORDS)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (word_index),
    .wdata (msg_word),
    .raddr (raddr),
    .rdata (rdata)
  );

  b3dh_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .go    (go),
    .busy  (busy),
    .done  (done),
    .raddr (raddr),
    .cmd   (cmd)
  );

  b3dh_dp #(
    .MSG_BYTES (MSG_BYTES)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .rdata       (rdata),
    .digest_word (digest_word)
  );

  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("done without busy");
  a_go_busy: assert property (@(posedge clk) disable iff (rst) go |=> busy)
    else $error("hash did not start");
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    done && is_last |=> !busy)
    else $error("busy after last beat");
  a_fell_busy: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> $past(done) && $past(is_last))
    else $error("busy dropped early");

endmodule
`default_nettype wire
